// ===== rtl/prbc_pkg.sv =====
// Types, constants and sine table for the point rotation about the box center.
`default_nettype none

package prbc_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int ANGLE_STEPS = 96;
	localparam int QUARTER_STEPS = ANGLE_STEPS / 4;
	localparam int STEP_WIDTH = 7;
	localparam int AXIS_WIDTH = 2;
	localparam int TRIG_FRAC = 14;
	localparam int TRIG_WIDTH = TRIG_FRAC + 2;
	localparam int DIFF_WIDTH = COORD_WIDTH + 1;
	localparam int PROD_WIDTH = DIFF_WIDTH + TRIG_WIDTH;
	localparam int ACC_WIDTH = PROD_WIDTH + 1;
	localparam int SHIFT_WIDTH = ACC_WIDTH - TRIG_FRAC;
	localparam int FULL_WIDTH = SHIFT_WIDTH + 1;
	localparam int CFG_INDEX_WIDTH = 2;
	localparam int CFG_DATA_WIDTH = STEP_WIDTH;

	localparam logic OP_MEASURE = 1'b0;
	localparam logic OP_TRANSFORM = 1'b1;

	localparam logic [AXIS_WIDTH-1:0] AXIS_X = 2'd0;
	localparam logic [AXIS_WIDTH-1:0] AXIS_Y = 2'd1;
	localparam logic [AXIS_WIDTH-1:0] AXIS_Z = 2'd2;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROTATION_AXIS = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROTATION_STEP = 2'd1;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [TRIG_WIDTH-1:0] trig_t;
	typedef logic signed [DIFF_WIDTH-1:0] diff_t;
	typedef logic signed [PROD_WIDTH-1:0] prod_t;
	typedef logic signed [FULL_WIDTH-1:0] full_t;

	typedef struct packed {
		logic opcode;
		logic first_point;
		coord_t coord_x;
		coord_t coord_y;
		coord_t coord_z;
	} in_item_t;

	typedef struct packed {
		coord_t rotated_x;
		coord_t rotated_y;
		coord_t rotated_z;
	} out_item_t;

	function automatic trig_t quarter_sin(input logic [4:0] i);
		trig_t r;
		case (i)
			5'd0: r = 16'sd0;
			5'd1: r = 16'sd1072;
			5'd2: r = 16'sd2139;
			5'd3: r = 16'sd3196;
			5'd4: r = 16'sd4240;
			5'd5: r = 16'sd5266;
			5'd6: r = 16'sd6270;
			5'd7: r = 16'sd7246;
			5'd8: r = 16'sd8192;
			5'd9: r = 16'sd9102;
			5'd10: r = 16'sd9974;
			5'd11: r = 16'sd10803;
			5'd12: r = 16'sd11585;
			5'd13: r = 16'sd12318;
			5'd14: r = 16'sd12998;
			5'd15: r = 16'sd13623;
			5'd16: r = 16'sd14189;
			5'd17: r = 16'sd14694;
			5'd18: r = 16'sd15137;
			5'd19: r = 16'sd15515;
			5'd20: r = 16'sd15826;
			5'd21: r = 16'sd16069;
			5'd22: r = 16'sd16244;
			5'd23: r = 16'sd16349;
			5'd24: r = 16'sd16384;
			default: r = 16'sd0;
		endcase
		return r;
	endfunction

	// k is already reduced below ANGLE_STEPS
	function automatic trig_t step_sin(input logic [STEP_WIDTH-1:0] k);
		logic [STEP_WIDTH-1:0] idx;
		trig_t r;
		if (k <= STEP_WIDTH'(QUARTER_STEPS)) begin
			r = quarter_sin(k[4:0]);
		end else if (k <= STEP_WIDTH'(2 * QUARTER_STEPS)) begin
			idx = STEP_WIDTH'(2 * QUARTER_STEPS) - k;
			r = quarter_sin(idx[4:0]);
		end else if (k <= STEP_WIDTH'(3 * QUARTER_STEPS)) begin
			idx = k - STEP_WIDTH'(2 * QUARTER_STEPS);
			r = -quarter_sin(idx[4:0]);
		end else begin
			idx = STEP_WIDTH'(ANGLE_STEPS) - k;
			r = -quarter_sin(idx[4:0]);
		end
		return r;
	endfunction

	function automatic logic [STEP_WIDTH-1:0] wrap_step(input logic [STEP_WIDTH-1:0] k);
		logic [STEP_WIDTH-1:0] r;
		if (k >= STEP_WIDTH'(ANGLE_STEPS))
			r = k - STEP_WIDTH'(ANGLE_STEPS);
		else
			r = k;
		return r;
	endfunction

	function automatic coord_t sat_coord(input full_t v);
		full_t hi;
		full_t lo;
		coord_t r;
		hi = FULL_WIDTH'({1'b0, {(COORD_WIDTH-1){1'b1}}});
		lo = -hi - FULL_WIDTH'(1);
		if (v > hi)
			r = {1'b0, {(COORD_WIDTH-1){1'b1}}};
		else if (v < lo)
			r = {1'b1, {(COORD_WIDTH-1){1'b0}}};
		else
			r = v[COORD_WIDTH-1:0];
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/point_rotate_about_box_center.sv =====
// Top level: bounding box measurement and rotation of points about its center.
//
// Input items arrive on in_valid / in_stall / in_data, results leave on
// out_valid / out_stall / out_data. A transfer happens at a rising edge with
// valid high and stall low. A measure item widens the running bounding box
// (first_point restarts it) and gives no result. A transform item gives one
// result: the point rotated by rotation_step * 2*pi/96 about the chosen axis,
// around the floored box center (0 while nothing is measured).
// Throughput is one item per cycle while in_stall is low. A transform result
// reaches out_data through the stages input register, center and difference,
// four 33x16 products, then sum, rounding and saturation.
// While out_stall is held the four stages fill, then in_stall rises;
// measure items leave at the input stage and never wait on the output.
// Configuration is written through cfg_wen / cfg_index / cfg_data while idle.
// Reset clears the box, the configuration and all stage valids.
`default_nettype none

module point_rotate_about_box_center
	import prbc_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire in_item_t                   in_data,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output out_item_t                       out_data,
	input  wire logic                       cfg_wen,
	input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

	logic [AXIS_WIDTH-1:0] rotation_axis_q;
	logic [STEP_WIDTH-1:0] rotation_step_q;
	coord_t box_min_x_q, box_max_x_q, box_min_y_q, box_max_y_q, box_min_z_q, box_max_z_q;
	logic box_valid_q;

	logic v_s1, v_s2, v_s3, v_s4;
	logic ready2, ready3, ready4, move1, accept, restart;
	in_item_t item_s1;

	diff_t d1_s2, d2_s2;
	trig_t sin_s2, cos_s2;
	coord_t c1_s2, c2_s2, x_s2, y_s2, z_s2;
	logic [AXIS_WIDTH-1:0] axis_s2;

	prod_t pcc_s3, pss_s3, psd_s3, pcd_s3;
	coord_t c1_s3, c2_s3, x_s3, y_s3, z_s3;
	logic [AXIS_WIDTH-1:0] axis_s3;

	out_item_t res_s4;

	coord_t cx, cy, cz;
	diff_t dx, dy, dz, d1, d2;
	coord_t c1, c2;
	logic [STEP_WIDTH-1:0] k_sin, k_cos;
	logic [COORD_WIDTH:0] sum_x, sum_y, sum_z;

	logic signed [ACC_WIDTH-1:0] acc_p, acc_q;
	logic signed [SHIFT_WIDTH-1:0] sh_p, sh_q;
	coord_t rp, rq;
	out_item_t res;

	assign ready4 = !v_s4 || !out_stall;
	assign ready3 = !v_s3 || ready4;
	assign ready2 = !v_s2 || ready3;
	assign move1 = v_s1 && (item_s1.opcode == OP_MEASURE || ready2);
	assign in_stall = v_s1 && !move1;
	assign accept = in_valid && !in_stall;
	assign restart = !box_valid_q || item_s1.first_point;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_axis_q <= AXIS_X;
			rotation_step_q <= '0;
		end else if (cfg_wen) begin
			if (cfg_index == REG_ROTATION_AXIS)
				rotation_axis_q <= cfg_data[AXIS_WIDTH-1:0];
			else if (cfg_index == REG_ROTATION_STEP)
				rotation_step_q <= cfg_data[STEP_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			box_valid_q <= 1'b0;
			box_min_x_q <= '0;
			box_max_x_q <= '0;
			box_min_y_q <= '0;
			box_max_y_q <= '0;
			box_min_z_q <= '0;
			box_max_z_q <= '0;
		end else begin
			if (accept)
				v_s1 <= 1'b1;
			else if (move1)
				v_s1 <= 1'b0;
			if (ready2)
				v_s2 <= move1 && item_s1.opcode == OP_TRANSFORM;
			if (ready3)
				v_s3 <= v_s2;
			if (ready4)
				v_s4 <= v_s3;
			if (move1 && item_s1.opcode == OP_MEASURE) begin
				box_valid_q <= 1'b1;
				if (restart || item_s1.coord_x < box_min_x_q) box_min_x_q <= item_s1.coord_x;
				if (restart || item_s1.coord_x > box_max_x_q) box_max_x_q <= item_s1.coord_x;
				if (restart || item_s1.coord_y < box_min_y_q) box_min_y_q <= item_s1.coord_y;
				if (restart || item_s1.coord_y > box_max_y_q) box_max_y_q <= item_s1.coord_y;
				if (restart || item_s1.coord_z < box_min_z_q) box_min_z_q <= item_s1.coord_z;
				if (restart || item_s1.coord_z > box_max_z_q) box_max_z_q <= item_s1.coord_z;
			end
		end
	end

	// center, differences and operand selection
	always_comb begin
		sum_x = {box_min_x_q[COORD_WIDTH-1], box_min_x_q} + {box_max_x_q[COORD_WIDTH-1], box_max_x_q};
		sum_y = {box_min_y_q[COORD_WIDTH-1], box_min_y_q} + {box_max_y_q[COORD_WIDTH-1], box_max_y_q};
		sum_z = {box_min_z_q[COORD_WIDTH-1], box_min_z_q} + {box_max_z_q[COORD_WIDTH-1], box_max_z_q};
		cx = box_valid_q ? sum_x[COORD_WIDTH:1] : '0;
		cy = box_valid_q ? sum_y[COORD_WIDTH:1] : '0;
		cz = box_valid_q ? sum_z[COORD_WIDTH:1] : '0;
		dx = DIFF_WIDTH'(item_s1.coord_x) - DIFF_WIDTH'(cx);
		dy = DIFF_WIDTH'(item_s1.coord_y) - DIFF_WIDTH'(cy);
		dz = DIFF_WIDTH'(item_s1.coord_z) - DIFF_WIDTH'(cz);
		case (rotation_axis_q)
			AXIS_X: begin
				d1 = dy;
				d2 = dz;
				c1 = cy;
				c2 = cz;
			end
			AXIS_Y: begin
				d1 = dz;
				d2 = dx;
				c1 = cz;
				c2 = cx;
			end
			AXIS_Z: begin
				d1 = dx;
				d2 = dy;
				c1 = cx;
				c2 = cy;
			end
			default: begin
				d1 = '0;
				d2 = '0;
				c1 = '0;
				c2 = '0;
			end
		endcase
		k_sin = wrap_step(rotation_step_q);
		k_cos = wrap_step(k_sin + STEP_WIDTH'(QUARTER_STEPS));
	end

	always_ff @(posedge clk) begin
		if (accept)
			item_s1 <= in_data;
		if (ready2) begin
			d1_s2 <= d1;
			d2_s2 <= d2;
			c1_s2 <= c1;
			c2_s2 <= c2;
			sin_s2 <= step_sin(k_sin);
			cos_s2 <= step_sin(k_cos);
			x_s2 <= item_s1.coord_x;
			y_s2 <= item_s1.coord_y;
			z_s2 <= item_s1.coord_z;
			axis_s2 <= rotation_axis_q;
		end
		if (ready3) begin
			pcc_s3 <= PROD_WIDTH'(d1_s2) * PROD_WIDTH'(cos_s2);
			pss_s3 <= PROD_WIDTH'(d2_s2) * PROD_WIDTH'(sin_s2);
			psd_s3 <= PROD_WIDTH'(d1_s2) * PROD_WIDTH'(sin_s2);
			pcd_s3 <= PROD_WIDTH'(d2_s2) * PROD_WIDTH'(cos_s2);
			c1_s3 <= c1_s2;
			c2_s3 <= c2_s2;
			x_s3 <= x_s2;
			y_s3 <= y_s2;
			z_s3 <= z_s2;
			axis_s3 <= axis_s2;
		end
		if (ready4)
			res_s4 <= res;
	end

	// round half up, recenter, saturate
	always_comb begin
		acc_p = ACC_WIDTH'(pcc_s3) - ACC_WIDTH'(pss_s3) + ACC_WIDTH'(2 ** (TRIG_FRAC - 1));
		acc_q = ACC_WIDTH'(psd_s3) + ACC_WIDTH'(pcd_s3) + ACC_WIDTH'(2 ** (TRIG_FRAC - 1));
		sh_p = acc_p[ACC_WIDTH-1:TRIG_FRAC];
		sh_q = acc_q[ACC_WIDTH-1:TRIG_FRAC];
		rp = sat_coord(FULL_WIDTH'(sh_p) + FULL_WIDTH'(c1_s3));
		rq = sat_coord(FULL_WIDTH'(sh_q) + FULL_WIDTH'(c2_s3));
		res.rotated_x = x_s3;
		res.rotated_y = y_s3;
		res.rotated_z = z_s3;
		case (axis_s3)
			AXIS_X: begin
				res.rotated_y = rp;
				res.rotated_z = rq;
			end
			AXIS_Y: begin
				res.rotated_z = rp;
				res.rotated_x = rq;
			end
			AXIS_Z: begin
				res.rotated_x = rp;
				res.rotated_y = rq;
			end
			default: begin
				res.rotated_x = x_s3;
			end
		endcase
	end

	assign out_valid = v_s4;
	assign out_data = res_s4;

endmodule

`default_nettype wire
